@@ design/x11csp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x11csp_pkg
// Shared types, codes and helper functions for the color specification parser.
// ----------------------------------------------------------------------------
package x11csp_pkg;

    // Parse mode codes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_HASH   = 2'd1;
    localparam logic [1:0] MODE_PREFIX = 2'd2;
    localparam logic [1:0] MODE_COMPS  = 2'd3;

    // Character codes
    localparam logic [7:0] CHAR_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CHAR_SLASH = 8'h2f;  // '/'
    localparam logic [7:0] CHAR_R     = 8'h72;  // 'r'
    localparam logic [7:0] CHAR_G     = 8'h67;  // 'g'
    localparam logic [7:0] CHAR_B     = 8'h62;  // 'b'
    localparam logic [7:0] CHAR_COLON = 8'h3a;  // ':'

    localparam logic [2:0] HASH_LEN      = 3'd7;
    localparam logic [2:0] PREFIX_LAST   = 3'd3;
    localparam logic [2:0] DIGIT_MAX     = 3'd4;
    localparam logic [2:0] DIGIT_SAT     = 3'd5;
    localparam logic [1:0] COMP_LAST     = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  char_count;
        logic [1:0]  comp_index;
        logic [2:0]  digit_count;
        logic [15:0] acc;
        logic [7:0]  saved_red;
        logic [7:0]  saved_green;
        logic        error_seen;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        mode:        MODE_START,
        char_count:  3'd0,
        comp_index:  2'd0,
        digit_count: 3'd0,
        acc:         16'd0,
        saved_red:   8'd0,
        saved_green: 8'd0,
        error_seen:  1'b0
    };

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } t_nibble8;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Decode one ASCII hex digit, either case
    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Expected prefix character at a given position
    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = CHAR_R;
            2'd1:    c = CHAR_G;
            2'd2:    c = CHAR_B;
            default: c = CHAR_COLON;
        endcase
        return c;
    endfunction

    // Scale a 1 to 4 digit component to 8 bits
    function automatic t_nibble8 scale_comp(input logic [15:0] acc,
                                            input logic [2:0] count);
        t_nibble8 s;
        s.ok = 1'b1;
        case (count)
            3'd1:    s.val = {acc[3:0], acc[3:0]};   // times 17
            3'd2:    s.val = acc[7:0];
            3'd3:    s.val = acc[11:4];
            3'd4:    s.val = acc[15:8];
            default: begin
                s.ok  = 1'b0;
                s.val = 8'd0;
            end
        endcase
        return s;
    endfunction

endpackage

@@ design/x11csp_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x11csp_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface x11csp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/x11csp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x11csp_step
// Next-state and result logic for one character of a color specification.
// ----------------------------------------------------------------------------
module x11csp_step
    import x11csp_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_char,
    input  logic         i_last,
    output t_parse_state o_next,
    output t_out_item    o_result
);

    t_parse_state n_s;
    t_hex         hex;
    t_nibble8     comp;
    t_nibble8     fin;

    always_comb begin
        hex  = hex_digit(i_char);
        comp = scale_comp(i_state.acc, i_state.digit_count);
        n_s  = i_state;

        if (!i_state.error_seen) begin
            case (i_state.mode)
                MODE_START: begin
                    if (i_char == CHAR_HASH) begin
                        n_s.mode = MODE_HASH;
                    end else if (i_char == CHAR_R) begin
                        n_s.mode = MODE_PREFIX;
                    end else begin
                        n_s.error_seen = 1'b1;
                    end
                end
                MODE_HASH: begin
                    if (!hex.ok || i_state.char_count >= HASH_LEN) begin
                        n_s.error_seen = 1'b1;
                    end else begin
                        n_s.acc = {8'd0, i_state.acc[3:0], hex.val};
                        if (i_state.char_count == 3'd2) begin
                            n_s.saved_red = {i_state.acc[3:0], hex.val};
                        end
                        if (i_state.char_count == 3'd4) begin
                            n_s.saved_green = {i_state.acc[3:0], hex.val};
                        end
                    end
                end
                MODE_PREFIX: begin
                    if (i_state.char_count > PREFIX_LAST ||
                        i_char != prefix_char(i_state.char_count[1:0])) begin
                        n_s.error_seen = 1'b1;
                    end else if (i_state.char_count == PREFIX_LAST) begin
                        n_s.mode = MODE_COMPS;
                    end
                end
                default: begin
                    if (i_char == CHAR_SLASH) begin
                        if (i_state.comp_index >= COMP_LAST || !comp.ok) begin
                            n_s.error_seen = 1'b1;
                        end else begin
                            if (i_state.comp_index == 2'd0) begin
                                n_s.saved_red = comp.val;
                            end else begin
                                n_s.saved_green = comp.val;
                            end
                            n_s.comp_index  = i_state.comp_index + 2'd1;
                            n_s.digit_count = 3'd0;
                            n_s.acc         = 16'd0;
                        end
                    end else if (!hex.ok) begin
                        n_s.error_seen = 1'b1;
                    end else begin
                        if (i_state.digit_count < DIGIT_MAX) begin
                            n_s.acc = {i_state.acc[11:0], hex.val};
                        end
                        if (i_state.digit_count < DIGIT_SAT) begin
                            n_s.digit_count = i_state.digit_count + 3'd1;
                        end
                    end
                end
            endcase
            if (i_state.char_count < HASH_LEN) begin
                n_s.char_count = i_state.char_count + 3'd1;
            end
        end

        // Result from the state after this character
        fin      = scale_comp(n_s.acc, n_s.digit_count);
        o_result = '0;
        if (!n_s.error_seen) begin
            if (n_s.mode == MODE_HASH && n_s.char_count == HASH_LEN) begin
                o_result.ok    = 1'b1;
                o_result.red   = n_s.saved_red;
                o_result.green = n_s.saved_green;
                o_result.blue  = n_s.acc[7:0];
            end else if (n_s.mode == MODE_COMPS && n_s.comp_index == COMP_LAST &&
                         fin.ok) begin
                o_result.ok    = 1'b1;
                o_result.red   = n_s.saved_red;
                o_result.green = n_s.saved_green;
                o_result.blue  = fin.val;
            end
        end

        // A finished specification starts the next one from scratch
        o_next = i_last ? PARSE_RESET : n_s;
    end

endmodule

@@ design/x11_color_spec_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x11_color_spec_parser_core
// Parses an X11 color specification ("#rrggbb" or "rgb:r/g/b") streamed one
// character per transfer and returns validity and 8-bit red, green, blue.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                        Transfers
//   i_in     in   char_code[7:0], is_last        one per character
//   o_out    out  ok, red[7:0], green[7:0],      one per character with
//                 blue[7:0]                      is_last set
//
// One character per cycle, sustained. A character is registered at its
// input transfer and then runs through the parse step; a final
// character's result is loaded into the result register, which drives
// o_out.valid until the result transfers. The parse step is the only loop.
// Reset (synchronous, active low) returns the parser to the start of a
// specification and empties both registers. While a result waits on
// o_out.ready, non-final characters still advance; only a final character
// holds in the input register until the result register frees up.
//
module x11_color_spec_parser_core
    import x11csp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    x11csp_stream_if.sink         i_in,
    x11csp_stream_if.source       o_out
);

    // Input register
    logic         r_s1_valid;
    logic [7:0]   r_s1_char;
    logic         r_s1_last;

    // Parser state and result register
    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    t_out_item    r_out_data;
    t_out_item    step_result;

    logic         in_xfer;
    logic         out_free;
    logic         s1_fire;

    // The result register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || o_out.ready;

    // Advance the held character unless it is final and the result is blocked
    assign s1_fire  = r_s1_valid && (!r_s1_last || out_free);

    assign i_in.ready = !r_s1_valid || s1_fire;
    assign in_xfer    = i_in.valid && i_in.ready;

    x11csp_step u_step (
        .i_state  (r_state),
        .i_char   (r_s1_char),
        .i_last   (r_s1_last),
        .o_next   (n_state),
        .o_result (step_result)
    );

    // Input register: take a new character whenever the slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_char <= i_in.data.char_code;
            r_s1_last <= i_in.data.is_last;
        end
    end

    // Parser state: update once per consumed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_RESET;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    // Result register: load on a final character, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_data <= step_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule
